// ===== rtl/nes_pkg.sv =====
package nes_pkg;

    // store geometry
    localparam int MAX_EVENTS = 64;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

    // field widths
    localparam int TIME_W    = 17;
    localparam int IN_TIME_W = 16;
    localparam int FIELD_W   = 7;
    localparam int STATUS_W  = 2;

    // command queue between front and back, depth kept a power of two
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QFILL_W = $clog2(QDEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_POP = 1'b1
    } t_cmd;

    // field order gives the sort order when compared as one unsigned word
    typedef struct packed {
        logic [TIME_W-1:0]  ev_time;
        logic [FIELD_W-1:0] ev_instrument;
        logic [FIELD_W-1:0] ev_pitch;
        logic [FIELD_W-1:0] ev_loudness;
    } t_event;

    typedef struct packed {
        t_cmd   cmd;
        t_event ev_on;
        t_event ev_off;
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_INS_OFF
    } t_back_state;

    typedef struct packed {
        logic             busy;
        logic             take;
        logic [CNT_W-1:0] count;
    } t_back_status;

endpackage

// ===== rtl/nes_front.sv =====
module nes_front
    import nes_pkg::*;
(
    input  logic                 i_cmd,
    input  logic [FIELD_W-1:0]   i_instrument,
    input  logic [FIELD_W-1:0]   i_pitch,
    input  logic [FIELD_W-1:0]   i_loudness,
    input  logic [IN_TIME_W-1:0] i_start_time,
    input  logic [IN_TIME_W-1:0] i_length,
    output t_op                  o_op
);

    logic [TIME_W-1:0] w_off_time;

    // note-off time, one bit wider than the inputs so it cannot wrap
    assign w_off_time = {1'b0, i_start_time} + {1'b0, i_length};

    // classify the command and build both events of a note
    always_comb begin
        o_op.cmd                  = t_cmd'(i_cmd);
        o_op.ev_on.ev_time        = {1'b0, i_start_time};
        o_op.ev_on.ev_instrument  = i_instrument;
        o_op.ev_on.ev_pitch       = i_pitch;
        o_op.ev_on.ev_loudness    = i_loudness;
        o_op.ev_off.ev_time       = w_off_time;
        o_op.ev_off.ev_instrument = i_instrument;
        o_op.ev_off.ev_pitch      = i_pitch;
        o_op.ev_off.ev_loudness   = '0;
    end

endmodule

// ===== rtl/nes_queue.sv =====
module nes_queue
    import nes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    t_op                r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;

    assign o_full  = (r_fill == QFILL_W'(QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_op    = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== rtl/nes_back.sv =====
module nes_back
    import nes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_op                 i_q_op,
    output t_back_status        o_status_bus,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TIME_W-1:0]   o_event_time,
    output logic [FIELD_W-1:0]  o_event_instrument,
    output logic [FIELD_W-1:0]  o_event_pitch,
    output logic [FIELD_W-1:0]  o_event_loudness
);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CNT_W-1:0] r_count;
    t_event           r_cell [MAX_EVENTS];
    t_event           r_off_ev;
    logic             r_out_valid;
    t_status          r_out_status;
    t_event           r_out_ev;

    logic                  w_slot_free;
    logic                  w_take;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins_en;
    logic                  w_pop_en;
    t_event                w_ins_ev;
    logic                  w_res_we;
    t_status               w_res_status;
    t_event                w_res_ev;
    logic [MAX_EVENTS-1:0] w_gt;

    // capacity checks on the live count
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_take      = (r_state == BK_IDLE) && i_q_valid && w_slot_free;
    assign w_full      = ({1'b0, r_count} + (CNT_W + 1)'(2)) > (CNT_W + 1)'(MAX_EVENTS);
    assign w_empty     = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (w_take && (i_q_op.cmd == CMD_ADD) && !w_full) begin
                    n_state = BK_INS_OFF;
                end
            end
            BK_INS_OFF: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        w_ins_en     = 1'b0;
        w_pop_en     = 1'b0;
        w_ins_ev     = r_off_ev;
        w_res_we     = 1'b0;
        w_res_status = ST_OK;
        w_res_ev     = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    w_res_we = 1'b1;
                    if (i_q_op.cmd == CMD_ADD) begin
                        if (w_full) begin
                            w_res_status = ST_FULL;
                        end else begin
                            w_ins_en = 1'b1;
                            w_ins_ev = i_q_op.ev_on;
                        end
                    end else begin
                        if (w_empty) begin
                            w_res_status = ST_EMPTY;
                        end else begin
                            w_pop_en = 1'b1;
                            w_res_ev = r_cell[0];
                        end
                    end
                end
            end
            BK_INS_OFF: begin
                w_ins_en = 1'b1;
                w_ins_ev = r_off_ev;
            end
            default: begin
                w_ins_en = 1'b0;
            end
        endcase
    end

    // per-cell compare: the new event goes ahead of every cell that is larger or empty
    always_comb begin
        for (int i = 0; i < MAX_EVENTS; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) ? (r_cell[i] > w_ins_ev) : 1'b1;
        end
    end

    // sorted cell chain: insert shifts right, pop shifts left
    for (genvar g = 0; g < MAX_EVENTS; g++) begin : g_cell
        t_event w_left;
        logic   w_left_gt;
        t_event w_right;

        if (g == 0) begin : g_head
            assign w_left    = w_ins_ev;
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = r_cell[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == MAX_EVENTS - 1) begin : g_tail
            assign w_right = r_cell[g];
        end else begin : g_inner
            assign w_right = r_cell[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (w_ins_en && w_gt[g]) begin
                r_cell[g] <= w_left_gt ? w_left : w_ins_ev;
            end else if (w_pop_en) begin
                r_cell[g] <= w_right;
            end
        end
    end

    // state, count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ins_en) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop_en) begin
                r_count <= r_count - 1'b1;
            end
            if (w_res_we) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // held note-off event and result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_off_ev <= i_q_op.ev_off;
        end
        if (w_res_we) begin
            r_out_status <= w_res_status;
            r_out_ev     <= w_res_ev;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_event_time       = r_out_ev.ev_time;
    assign o_event_instrument = r_out_ev.ev_instrument;
    assign o_event_pitch      = r_out_ev.ev_pitch;
    assign o_event_loudness   = r_out_ev.ev_loudness;

    assign o_status_bus.busy  = (r_state == BK_INS_OFF);
    assign o_status_bus.take  = w_take;
    assign o_status_bus.count = r_count;

endmodule

// ===== rtl/note_event_sorter_unit.sv =====
// Sorted note-event store. A front stage packs each transaction into a note-on and a
// note-off event and places it in a two-deep command queue; the back end keeps up to
// MAX_EVENTS events in a chain of cells ordered by time, instrument, pitch and intensity,
// and every cell compares itself with the incoming event so that one insertion completes
// per cycle. An add makes two insertions in the back end, the note-on from the idle state
// and the note-off from BK_INS_OFF, which takes no transaction; a pop or a rejected add is
// done in the idle state alone. Every transaction yields exactly one result; adds and full
// or empty reports carry zero event fields. The store needs no clearing pass after reset.
module note_event_sorter_unit
    import nes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [FIELD_W-1:0]   i_instrument,
    input  logic [FIELD_W-1:0]   i_pitch,
    input  logic [FIELD_W-1:0]   i_loudness,
    input  logic [IN_TIME_W-1:0] i_start_time,
    input  logic [IN_TIME_W-1:0] i_length,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [TIME_W-1:0]    o_event_time,
    output logic [FIELD_W-1:0]   o_event_instrument,
    output logic [FIELD_W-1:0]   o_event_pitch,
    output logic [FIELD_W-1:0]   o_event_loudness
);

    t_op          w_front_op;
    t_op          w_q_op;
    logic         w_q_full;
    logic         w_q_valid;
    logic         w_push;
    t_back_status w_bk_status;

    assign w_push  = i_valid && !w_q_full;
    assign o_stall = w_q_full;

    // decode and event packing
    nes_front u_front (
        .i_cmd        (i_cmd),
        .i_instrument (i_instrument),
        .i_pitch      (i_pitch),
        .i_loudness   (i_loudness),
        .i_start_time (i_start_time),
        .i_length     (i_length),
        .o_op         (w_front_op)
    );

    // command queue
    nes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_bk_status.take)
    );

    // sorted store and result register
    nes_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (w_q_valid),
        .i_q_op             (w_q_op),
        .o_status_bus       (w_bk_status),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_event_time       (o_event_time),
        .o_event_instrument (o_event_instrument),
        .o_event_pitch      (o_event_pitch),
        .o_event_loudness   (o_event_loudness)
    );

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_status.count <= CNT_W'(MAX_EVENTS))
        else $error("event count above capacity");

    a_no_take_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_status.busy |-> !w_bk_status.take)
        else $error("queue entry taken during note-off insertion");

    a_on_inserted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_bk_status.busy) |-> w_bk_status.count == $past(w_bk_status.count) + 1'b1)
        else $error("note-on insertion did not advance the count");
`endif

endmodule
